FILE: rtl/base32_stream_encoder_macros.svh
// Assertion macros shared by the Base32 encoder RTL.
// No dependencies; include once per file that asserts.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B32_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B32_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b32_pkg.sv
// Shared types, constants and character functions for the Base32 encoder.
// No dependencies.
`timescale 1ns / 1ps
package b32_pkg;

  localparam int GQ_DEPTH = 2;
  localparam int GQ_AW    = $clog2(GQ_DEPTH);

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [7:0] CHAR_UPPER  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_DIGIT  = 8'h32;  // '2'
  localparam logic [4:0] ALPHA_SPLIT = 5'd26;
  localparam logic [2:0] GROUP_BYTES = 3'd5;
  localparam logic [2:0] MAX_PEND    = 3'd4;
  localparam logic [2:0] LAST_POS    = 3'd7;

  // One gathered group, aligned to the top of a 40-bit word.
  typedef struct packed {
    logic [39:0] bits;
    logic [3:0]  keep;   // data characters before padding
    logic        last;   // group ends the message
  } b32_group_t;

  // Map a 5-bit value to the standard alphabet.
  function automatic logic [7:0] b32_char(input logic [4:0] v);
    logic [7:0] c;
    if (v < ALPHA_SPLIT) begin
      c = 8'(CHAR_UPPER + {3'b000, v});
    end else begin
      c = 8'(CHAR_DIGIT + {3'b000, 5'(v - ALPHA_SPLIT)});
    end
    return c;
  endfunction

  // Data characters for a group of n bytes.
  function automatic logic [3:0] b32_keep(input logic [2:0] n);
    logic [3:0] k;
    unique case (n)
      3'd1:    k = 4'd2;
      3'd2:    k = 4'd4;
      3'd3:    k = 4'd5;
      3'd4:    k = 4'd7;
      default: k = 4'd8;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/b32_front.sv
// Byte gatherer: collects up to five bytes and issues aligned groups.
// Depends on b32_pkg.
`timescale 1ns / 1ps
module b32_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               message_last,
  input  logic               grp_full,
  output logic               grp_push,
  output b32_pkg::b32_group_t grp
);
  import b32_pkg::*;

  logic [31:0] pend;
  logic [2:0]  cnt;
  logic [2:0]  n;
  logic        accept;
  logic        close;

  assign full   = grp_full;
  assign accept = push && !grp_full;
  assign n      = ((cnt > MAX_PEND) ? MAX_PEND : cnt) + 3'd1;
  assign close  = (n == GROUP_BYTES) || message_last;
  assign grp_push = accept && close;

  always_comb begin
    unique case (n)
      3'd1:    grp.bits = {data_byte, 32'h0};
      3'd2:    grp.bits = {pend[7:0], data_byte, 24'h0};
      3'd3:    grp.bits = {pend[15:0], data_byte, 16'h0};
      3'd4:    grp.bits = {pend[23:0], data_byte, 8'h0};
      default: grp.bits = {pend, data_byte};
    endcase
    grp.keep = b32_keep(n);
    grp.last = message_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (accept) begin
      if (close) begin
        pend <= '0;
        cnt  <= '0;
      end else begin
        pend <= {pend[23:0], data_byte};
        cnt  <= n;
      end
    end
  end

endmodule

FILE: rtl/b32_queue.sv
// Short group queue between the gatherer and the character serialiser.
// Depends on b32_pkg.
`timescale 1ns / 1ps
module b32_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  b32_pkg::b32_group_t wr_data,
  output logic                full,
  input  logic                rd,
  output b32_pkg::b32_group_t rd_data,
  output logic                empty
);
  import b32_pkg::*;

  b32_group_t           mem [GQ_DEPTH];
  logic [GQ_AW-1:0]     wp;
  logic [GQ_AW-1:0]     rp;
  logic [GQ_AW:0]       count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == (GQ_AW+1)'(GQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == GQ_AW'(GQ_DEPTH - 1)) ? '0 : GQ_AW'(wp + 1'b1);
      end
      if (do_rd) begin
        rp <= (rp == GQ_AW'(GQ_DEPTH - 1)) ? '0 : GQ_AW'(rp + 1'b1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= (GQ_AW+1)'(count + 1'b1);
        2'b01:   count <= (GQ_AW+1)'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/b32_back.sv
// Character serialiser: eight characters per group, one a cycle if not stalled.
// Depends on b32_pkg and base32_stream_encoder_macros.svh.
`timescale 1ns / 1ps
`include "base32_stream_encoder_macros.svh"
module b32_back (
  input  logic                clk,
  input  logic                rst,
  input  b32_pkg::b32_group_t grp,
  input  logic                grp_empty,
  output logic                grp_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_char,
  output logic                group_last,
  output logic                message_end
);
  import b32_pkg::*;

  logic [39:0] sr;
  logic [3:0]  keep;
  logic        last;
  logic [2:0]  k;
  logic        busy;
  logic        out_valid;
  logic        advance;
  logic        load;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign load    = !grp_empty && (!busy || (advance && (k == LAST_POS)));
  assign grp_pop = load;

  always_ff @(posedge clk) begin
    if (load) begin
      sr   <= grp.bits;
      keep <= grp.keep;
      last <= grp.last;
    end else if (advance && busy) begin
      sr <= {sr[34:0], 5'b00000};
    end
    if (advance && busy) begin
      out_char    <= ({1'b0, k} < keep) ? b32_char(sr[39:35]) : PAD_CHAR;
      group_last  <= (k == LAST_POS);
      message_end <= (k == LAST_POS) && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (advance && busy) begin
        k <= 3'(k + 1'b1);
      end
      if (load) begin
        busy <= 1'b1;
      end else if (advance && busy && (k == LAST_POS)) begin
        busy <= 1'b0;
      end
    end
  end

  `B32_ASSERT_IMPL(a_idle_pos_zero, clk, rst, !busy, k == '0, "position moved while idle")
  `B32_ASSERT_IMPL(a_end_on_group_last, clk, rst, out_valid && message_end, group_last, "message end off group boundary")
  `B32_ASSERT_NEXT(a_load_starts_group, clk, rst, load, busy && (k == '0), "group load did not restart position")

endmodule

FILE: rtl/base32_stream_encoder.sv
// The closing byte's group is written to the queue, loaded into the serialiser's shift
// register and then registered onto the character ports. Characters leave one per cycle
// while pop keeps up, eight per group, through the serialiser's single character path.
// Bytes enter at one per cycle while a queue slot is free; a short message still yields
// eight characters however few bytes it holds. Reset (synchronous, rst high) empties the
// queue, clears the pending bytes and count, and drops any group being serialised.
`timescale 1ns / 1ps
module base32_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       message_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       group_last,
  output logic       message_end
);
  import b32_pkg::*;

  // Groups travel from gatherer to serialiser through the queue, so a stalled
  // result side only back-pressures input once both queue slots are taken.
  b32_group_t grp_in;
  b32_group_t grp_out;
  logic       grp_push;
  logic       grp_full;
  logic       grp_pop;
  logic       grp_empty;

  // Front: gather bytes, close a group on the fifth byte or the final byte.
  b32_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .message_last (message_last),
    .grp_full     (grp_full),
    .grp_push     (grp_push),
    .grp          (grp_in)
  );

  // Queue: hold closed groups until the serialiser is free.
  b32_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (grp_push),
    .wr_data (grp_in),
    .full    (grp_full),
    .rd      (grp_pop),
    .rd_data (grp_out),
    .empty   (grp_empty)
  );

  // Back: emit eight characters per group; the next group loads as the
  // eighth character of the current one advances, so queued groups run gap-free.
  b32_back u_back (
    .clk         (clk),
    .rst         (rst),
    .grp         (grp_out),
    .grp_empty   (grp_empty),
    .grp_pop     (grp_pop),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .group_last  (group_last),
    .message_end (message_end)
  );

endmodule
